### hw/rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Types and constants shared by the triangle pixel shader modules.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned DIFF_W    = 18;
  localparam int unsigned PROD_W    = 2 * DIFF_W;
  localparam int unsigned EDGE_W    = PROD_W + 1;
  localparam int unsigned WGT_W     = PROD_W;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned NUM_W     = WGT_W + CHAN_W + 2;
  localparam int unsigned IDX_W     = 18;
  localparam int unsigned PIX_W     = 9;
  localparam int unsigned NCHAN     = 3;
  localparam int unsigned DIV_STEPS = CHAN_W;

  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned MID_CNT_W = $clog2(MID_DEPTH) + 1;
  localparam int unsigned OUT_DEPTH = 16;
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH) + 1;
  localparam int unsigned BACK_LAT  = DIV_STEPS + 2;
  localparam int unsigned FLIGHT_W  = $clog2(BACK_LAT + 1);

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERTEX_A = 3'd0,
    CFG_VERTEX_B = 3'd1,
    CFG_VERTEX_C = 3'd2,
    CFG_COLOR_A  = 3'd3,
    CFG_COLOR_B  = 3'd4,
    CFG_COLOR_C  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] vertex_a_xy;
    logic [31:0] vertex_b_xy;
    logic [31:0] vertex_c_xy;
    logic [23:0] color_a_rgb;
    logic [23:0] color_b_rgb;
    logic [23:0] color_c_rgb;
  } tps_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic              covered;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [IDX_W-1:0]  pixel_index;
  } pix_out_t;

  typedef struct packed {
    logic             covered;
    logic [WGT_W-1:0] w0;
    logic [WGT_W-1:0] w1;
    logic [WGT_W-1:0] w2;
    logic [WGT_W-1:0] area;
    logic [IDX_W-1:0] pixel_index;
  } tps_item_t;

endpackage

### hw/rtl/tps_fifo.sv
// ----------------------------------------------------------------------------
// tps_fifo
// Small register queue with occupancy count; callers never overfill it.
// ----------------------------------------------------------------------------
module tps_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [WIDTH-1:0]         data_i,
  input  logic                     pop_i,
  output logic [WIDTH-1:0]         data_o,
  output logic [$clog2(DEPTH):0]   count_o
);
  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

### hw/rtl/tps_front.sv
// ----------------------------------------------------------------------------
// tps_front
// Edge evaluation: differences, products, edge values and coverage test.
// ----------------------------------------------------------------------------
module tps_front #(
  parameter int unsigned FRAME_WIDTH = 512,
  parameter int unsigned FRAC_BITS   = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tps_pkg::tps_cfg_t           cfg_i,
  input  logic                        push_i,
  input  tps_pkg::pix_in_t            pix_i,
  input  logic [tps_pkg::MID_CNT_W-1:0] mid_count_i,
  output logic                        full_o,
  output logic                        mid_push_o,
  output tps_pkg::tps_item_t          mid_item_o
);
  import tps_pkg::*;

  localparam logic [DIFF_W-1:0] HALF = DIFF_W'(1) << (FRAC_BITS - 1);
  localparam logic [IDX_W-1:0]  FW   = IDX_W'(FRAME_WIDTH);

  logic signed [DIFF_W-1:0] ax, ay, bx, by, cx, cy, qx, qy;
  logic signed [DIFF_W-1:0] d_q [14];
  logic signed [DIFF_W-1:0] d_d [14];
  logic signed [PROD_W-1:0] p_q [8];
  logic        [IDX_W-1:0]  idx1_q, idx2_q;
  logic                     v1_q, v2_q;
  logic signed [EDGE_W-1:0] e_area, e0, e1, e2;
  logic                     accept;

  assign accept = push_i && !full_o;
  assign full_o = (MID_CNT_W+1)'(mid_count_i) + (MID_CNT_W+1)'(v1_q) + (MID_CNT_W+1)'(v2_q)
                  >= (MID_CNT_W+1)'(MID_DEPTH);

  always_comb begin
    ax = DIFF_W'(cfg_i.vertex_a_xy[31:16]);
    ay = DIFF_W'(cfg_i.vertex_a_xy[15:0]);
    bx = DIFF_W'(cfg_i.vertex_b_xy[31:16]);
    by = DIFF_W'(cfg_i.vertex_b_xy[15:0]);
    cx = DIFF_W'(cfg_i.vertex_c_xy[31:16]);
    cy = DIFF_W'(cfg_i.vertex_c_xy[15:0]);
    qx = (DIFF_W'(pix_i.pixel_x) << FRAC_BITS) | HALF;
    qy = (DIFF_W'(pix_i.pixel_y) << FRAC_BITS) | HALF;
    // area
    d_d[0]  = cx - ax;  d_d[1]  = by - ay;
    d_d[2]  = cy - ay;  d_d[3]  = bx - ax;
    // w0 from edge b-c
    d_d[4]  = qx - bx;  d_d[5]  = cy - by;
    d_d[6]  = qy - by;  d_d[7]  = cx - bx;
    // w1 from edge c-a
    d_d[8]  = qx - cx;  d_d[9]  = ay - cy;
    d_d[10] = qy - cy;  d_d[11] = ax - cx;
    // w2 from edge a-b
    d_d[12] = qx - ax;  d_d[13] = qy - ay;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q    <= d_d;
    idx1_q <= IDX_W'(pix_i.pixel_y) * FW + IDX_W'(pix_i.pixel_x);
    idx2_q <= idx1_q;
    p_q[0] <= d_q[0] * d_q[1];
    p_q[1] <= d_q[2] * d_q[3];
    p_q[2] <= d_q[4] * d_q[5];
    p_q[3] <= d_q[6] * d_q[7];
    p_q[4] <= d_q[8] * d_q[9];
    p_q[5] <= d_q[10] * d_q[11];
    p_q[6] <= d_q[12] * d_q[1];
    p_q[7] <= d_q[13] * d_q[3];
  end

  always_comb begin
    e_area = EDGE_W'(p_q[0]) - EDGE_W'(p_q[1]);
    e0     = EDGE_W'(p_q[2]) - EDGE_W'(p_q[3]);
    e1     = EDGE_W'(p_q[4]) - EDGE_W'(p_q[5]);
    e2     = EDGE_W'(p_q[6]) - EDGE_W'(p_q[7]);
    mid_item_o.covered     = (e_area > 0) && !e0[EDGE_W-1] && !e1[EDGE_W-1]
                             && !e2[EDGE_W-1];
    mid_item_o.w0          = e0[WGT_W-1:0];
    mid_item_o.w1          = e1[WGT_W-1:0];
    mid_item_o.w2          = e2[WGT_W-1:0];
    mid_item_o.area        = e_area[WGT_W-1:0];
    mid_item_o.pixel_index = idx2_q;
  end

  assign mid_push_o = v2_q;

endmodule

### hw/rtl/tps_back.sv
// ----------------------------------------------------------------------------
// tps_back
// Colour blend and pipelined restoring division by the triangle area.
// ----------------------------------------------------------------------------
module tps_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tps_pkg::tps_cfg_t             cfg_i,
  input  logic [tps_pkg::MID_CNT_W-1:0] mid_count_i,
  input  tps_pkg::tps_item_t            mid_item_i,
  output logic                          mid_pop_o,
  input  logic [tps_pkg::OUT_CNT_W-1:0] out_count_i,
  output logic                          out_push_o,
  output tps_pkg::pix_out_t             out_item_o
);
  import tps_pkg::*;

  logic [FLIGHT_W-1:0] flight_q, flight_d;
  logic                issue;

  tps_item_t           b0_q;
  logic                b0_v_q;
  logic [WGT_W+CHAN_W-1:0] pr_q [NCHAN][3];
  logic [WGT_W-1:0]    b1_area_q;
  logic [IDX_W-1:0]    b1_idx_q;
  logic                b1_cov_q, b1_v_q;

  logic [NUM_W-1:0]    rem_in [DIV_STEPS][NCHAN];
  logic [CHAN_W-1:0]   quo_in [DIV_STEPS][NCHAN];
  logic [WGT_W-1:0]    area_in [DIV_STEPS];
  logic [IDX_W-1:0]    idx_in [DIV_STEPS];
  logic                cov_in [DIV_STEPS];
  logic                v_in [DIV_STEPS];

  logic [NUM_W-1:0]    rem_q [DIV_STEPS][NCHAN];
  logic [CHAN_W-1:0]   quo_q [DIV_STEPS][NCHAN];
  logic [WGT_W-1:0]    area_q [DIV_STEPS];
  logic [IDX_W-1:0]    idx_q [DIV_STEPS];
  logic                cov_q [DIV_STEPS];
  logic                v_q [DIV_STEPS];

  logic [CHAN_W-1:0]   col [NCHAN][3];

  assign issue = (mid_count_i != '0) &&
                 ((OUT_CNT_W+1)'(out_count_i) + (OUT_CNT_W+1)'(flight_q)
                  < (OUT_CNT_W+1)'(OUT_DEPTH));
  assign mid_pop_o  = issue;
  assign out_push_o = v_q[DIV_STEPS-1];

  always_comb begin
    flight_d = flight_q + FLIGHT_W'(issue) - FLIGHT_W'(out_push_o);
  end

  always_comb begin
    for (int c = 0; c < NCHAN; c++) begin
      col[c][0] = cfg_i.color_a_rgb[CHAN_W*(NCHAN-1-c) +: CHAN_W];
      col[c][1] = cfg_i.color_b_rgb[CHAN_W*(NCHAN-1-c) +: CHAN_W];
      col[c][2] = cfg_i.color_c_rgb[CHAN_W*(NCHAN-1-c) +: CHAN_W];
    end
  end

  always_comb begin
    for (int s = 0; s < DIV_STEPS; s++) begin
      if (s == 0) begin
        for (int c = 0; c < NCHAN; c++) begin
          rem_in[s][c] = NUM_W'(pr_q[c][0]) + NUM_W'(pr_q[c][1]) + NUM_W'(pr_q[c][2]);
          quo_in[s][c] = '0;
        end
        area_in[s] = b1_area_q;
        idx_in[s]  = b1_idx_q;
        cov_in[s]  = b1_cov_q;
        v_in[s]    = b1_v_q;
      end else begin
        for (int c = 0; c < NCHAN; c++) begin
          rem_in[s][c] = rem_q[s-1][c];
          quo_in[s][c] = quo_q[s-1][c];
        end
        area_in[s] = area_q[s-1];
        idx_in[s]  = idx_q[s-1];
        cov_in[s]  = cov_q[s-1];
        v_in[s]    = v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flight_q <= '0;
      b0_v_q   <= 1'b0;
      b1_v_q   <= 1'b0;
      for (int s = 0; s < DIV_STEPS; s++) begin
        v_q[s] <= 1'b0;
      end
    end else begin
      flight_q <= flight_d;
      b0_v_q   <= issue;
      b1_v_q   <= b0_v_q;
      for (int s = 0; s < DIV_STEPS; s++) begin
        v_q[s] <= v_in[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic [NUM_W-1:0] sub;
    logic             ge;
    b0_q      <= mid_item_i;
    b1_area_q <= b0_q.area;
    b1_idx_q  <= b0_q.pixel_index;
    b1_cov_q  <= b0_q.covered;
    for (int c = 0; c < NCHAN; c++) begin
      pr_q[c][0] <= b0_q.w0 * col[c][0];
      pr_q[c][1] <= b0_q.w1 * col[c][1];
      pr_q[c][2] <= b0_q.w2 * col[c][2];
    end
    for (int s = 0; s < DIV_STEPS; s++) begin
      for (int c = 0; c < NCHAN; c++) begin
        sub = NUM_W'(area_in[s]) << (DIV_STEPS - 1 - s);
        ge  = rem_in[s][c] >= sub;
        rem_q[s][c] <= ge ? rem_in[s][c] - sub : rem_in[s][c];
        quo_q[s][c] <= {quo_in[s][c][CHAN_W-2:0], ge};
      end
      area_q[s] <= area_in[s];
      idx_q[s]  <= idx_in[s];
      cov_q[s]  <= cov_in[s];
    end
  end

  always_comb begin
    out_item_o.covered     = cov_q[DIV_STEPS-1];
    out_item_o.red_out     = cov_q[DIV_STEPS-1] ? quo_q[DIV_STEPS-1][0] : '0;
    out_item_o.green_out   = cov_q[DIV_STEPS-1] ? quo_q[DIV_STEPS-1][1] : '0;
    out_item_o.blue_out    = cov_q[DIV_STEPS-1] ? quo_q[DIV_STEPS-1][2] : '0;
    out_item_o.pixel_index = idx_q[DIV_STEPS-1];
  end

endmodule

### hw/rtl/triangle_pixel_shader.sv
// ----------------------------------------------------------------------------
// triangle_pixel_shader
// Edge-function rasteriser with barycentric colour interpolation.
// ----------------------------------------------------------------------------
// Usage: write the three vertices (unsigned fixed point, x in 31:16, y in
// 15:0) and the three vertex colours through the cfg channel while idle;
// cfg_ready_o is always high. Push pixel coordinates with push while full
// is low; results come out in order, one per pixel, on out_data_o while
// empty is low and are taken with pop.
// Throughput: one pixel per clock while full is low. A pushed pixel passes
// through two front stages (differences, products), the four-entry
// queue, then the back end with one capture stage, one blend product stage
// and eight restoring division steps by the triangle area (the blend sum
// feeds the first step), all three colour channels in parallel, then the
// sixteen-entry result queue.
// Reset clears the configuration and the valid bits and empties both
// queues. When pop is held low the result queue fills, the back end stops
// issuing, the middle queue fills and full rises; no item is lost and
// pushing resumes as soon as results are taken.
module triangle_pixel_shader #(
  parameter int unsigned FRAME_WIDTH = 512,
  parameter int unsigned FRAC_BITS   = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tps_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  tps_pkg::pix_in_t              in_data_i,
  output logic                          empty,
  input  logic                          pop,
  output tps_pkg::pix_out_t             out_data_o
);
  import tps_pkg::*;

  tps_cfg_t             cfg_q;
  logic                 mid_push, mid_pop, out_push;
  tps_item_t            mid_in, mid_out;
  logic [MID_CNT_W-1:0] mid_count;
  logic [OUT_CNT_W-1:0] out_count;
  pix_out_t             out_in;
  logic                 out_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_VERTEX_A: cfg_q.vertex_a_xy <= cfg_data_i;
        CFG_VERTEX_B: cfg_q.vertex_b_xy <= cfg_data_i;
        CFG_VERTEX_C: cfg_q.vertex_c_xy <= cfg_data_i;
        CFG_COLOR_A:  cfg_q.color_a_rgb <= cfg_data_i[23:0];
        CFG_COLOR_B:  cfg_q.color_b_rgb <= cfg_data_i[23:0];
        CFG_COLOR_C:  cfg_q.color_c_rgb <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  tps_front #(
    .FRAME_WIDTH(FRAME_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .pix_i      (in_data_i),
    .mid_count_i(mid_count),
    .full_o     (full),
    .mid_push_o (mid_push),
    .mid_item_o (mid_in)
  );

  tps_fifo #(
    .WIDTH($bits(tps_item_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .data_i (mid_in),
    .pop_i  (mid_pop),
    .data_o (mid_out),
    .count_o(mid_count)
  );

  tps_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .mid_count_i(mid_count),
    .mid_item_i (mid_out),
    .mid_pop_o  (mid_pop),
    .out_count_i(out_count),
    .out_push_o (out_push),
    .out_item_o (out_in)
  );

  assign out_pop = pop && !empty;
  assign empty   = (out_count == '0);

  tps_fifo #(
    .WIDTH($bits(pix_out_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (out_in),
    .pop_i  (out_pop),
    .data_o (out_data_o),
    .count_o(out_count)
  );

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the triangle pixel shader. Vertices and colours are set over
// the config channel, pixels are pushed with random gaps, results are popped
// with random stalls and compared field by field with an edge-function model.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tps_pkg::*;

  localparam int unsigned WIDTH = 512;
  localparam int unsigned FRAC  = 6;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  logic                 push = 1'b0;
  logic                 full;
  pix_in_t              in_data_i = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  pix_out_t             out_data_o;

  triangle_pixel_shader i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [31:0] vert_a, vert_b, vert_c;
  logic [23:0] col_a, col_b, col_c;
  pix_out_t    pending_pixels[$];
  int          n_errors = 0;
  int          n_shaded = 0;
  int          n_covered = 0;
  int          n_pixels = 0;
  int          n_setups = 0;
  longint unsigned n_cycles = 0;
  bit          hold_off = 1'b0;

  function automatic longint signed edge_fn(longint signed ax, longint signed ay,
      longint signed bx, longint signed by, longint signed px, longint signed py);
    return (px - ax) * (by - ay) - (py - ay) * (bx - ax);
  endfunction

  function automatic logic [7:0] blend(longint signed w0, longint signed w1,
      longint signed w2, longint signed area, int sh);
    longint signed q;
    q = (w0 * col_a[sh+:8] + w1 * col_b[sh+:8] + w2 * col_c[sh+:8]) / area;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic pix_out_t shade_pixel(pix_in_t p);
    longint signed ax, ay, bx, by, cx, cy, qx, qy, area, w0, w1, w2;
    pix_out_t r;
    ax = longint'(vert_a[31:16]); ay = longint'(vert_a[15:0]);
    bx = longint'(vert_b[31:16]); by = longint'(vert_b[15:0]);
    cx = longint'(vert_c[31:16]); cy = longint'(vert_c[15:0]);
    qx = (longint'(p.pixel_x) << FRAC) + (1 << (FRAC - 1));
    qy = (longint'(p.pixel_y) << FRAC) + (1 << (FRAC - 1));
    area = edge_fn(ax, ay, bx, by, cx, cy);
    w0 = edge_fn(bx, by, cx, cy, qx, qy);
    w1 = edge_fn(cx, cy, ax, ay, qx, qy);
    w2 = edge_fn(ax, ay, bx, by, qx, qy);
    r = '0;
    r.covered = (area > 0) && (w0 >= 0) && (w1 >= 0) && (w2 >= 0);
    if (r.covered) begin
      r.red_out   = blend(w0, w1, w2, area, 16);
      r.green_out = blend(w0, w1, w2, area, 8);
      r.blue_out  = blend(w0, w1, w2, area, 0);
    end
    r.pixel_index = IDX_W'(longint'(p.pixel_y) * WIDTH + p.pixel_x);
    return r;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_pixel(logic [8:0] x, logic [8:0] y);
    pix_in_t p;
    int g;
    p.pixel_x = x;
    p.pixel_y = y;
    push <= 1'b1;
    in_data_i <= p;
    do @(posedge clk_i); while (full);
    pending_pixels.push_back(shade_pixel(p));
    n_pixels++;
    if ($urandom_range(0, 3) != 0) begin
      g = gap_len();
      if (g != 0) begin
        push <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_VERTEX_A: vert_a = val;
      CFG_VERTEX_B: vert_b = val;
      CFG_VERTEX_C: vert_c = val;
      CFG_COLOR_A:  col_a = val[23:0];
      CFG_COLOR_B:  col_b = val[23:0];
      CFG_COLOR_C:  col_c = val[23:0];
      default: ;
    endcase
  endtask

  task automatic set_triangle(logic [31:0] a, logic [31:0] b, logic [31:0] c,
      logic [23:0] ca, logic [23:0] cb, logic [23:0] cc);
    write_reg(CFG_VERTEX_A, a);
    write_reg(CFG_VERTEX_B, b);
    write_reg(CFG_VERTEX_C, c);
    write_reg(CFG_COLOR_A, {8'h0, ca});
    write_reg(CFG_COLOR_B, {8'h0, cb});
    write_reg(CFG_COLOR_C, {8'h0, cc});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    n_setups++;
  endtask

  function automatic logic [31:0] fx(int x, int y);
    return {16'(x << FRAC), 16'(y << FRAC)};
  endfunction

  // counter-clockwise in the edge sense used here: area positive
  task automatic test_directed();
    set_triangle(fx(0, 0), fx(0, 16), fx(16, 0), 24'hFF0000, 24'h00FF00, 24'h0000FF);
    send_pixel(0, 0);
    send_pixel(5, 5);
    send_pixel(15, 0);
    send_pixel(0, 15);
    send_pixel(8, 7);
    send_pixel(20, 20);
    send_pixel(511, 511);
    send_pixel(511, 0);
    send_pixel(0, 511);
    drain();
    // pixel centre exactly on an edge
    set_triangle({16'd32, 16'd32}, {16'd32, 16'd800}, {16'd800, 16'd32},
                 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_pixel(0, 0);
    send_pixel(0, 5);
    send_pixel(5, 0);
    send_pixel(3, 3);
    drain();
    // clockwise and degenerate triangles never cover
    set_triangle(fx(0, 0), fx(16, 0), fx(0, 16), 24'h123456, 24'h789ABC, 24'hDEF012);
    send_pixel(2, 2);
    send_pixel(0, 0);
    drain();
    set_triangle(fx(1, 1), fx(5, 5), fx(9, 9), 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_pixel(5, 5);
    drain();
    // largest coordinates
    set_triangle(32'h0000_0000, 32'h0000_FFFF, 32'hFFFF_0000,
                 24'hFFFFFF, 24'h000000, 24'h808080);
    send_pixel(511, 511);
    send_pixel(0, 0);
    send_pixel(256, 100);
    send_pixel(100, 256);
    drain();
  endtask

  task automatic random_triangle();
    logic [31:0] a, b, c, t;
    int span;
    span = ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(512, 8000);
    a = {16'($urandom_range(0, span)), 16'($urandom_range(0, span))};
    b = {16'($urandom_range(0, span)), 16'($urandom_range(0, span))};
    c = {16'($urandom_range(0, span)), 16'($urandom_range(0, span))};
    // mostly keep a positive area so that many pixels are covered
    vert_a = a; vert_b = b; vert_c = c;
    if ($urandom_range(0, 4) != 0 &&
        edge_fn(longint'(a[31:16]), longint'(a[15:0]), longint'(b[31:16]),
                longint'(b[15:0]), longint'(c[31:16]), longint'(c[15:0])) < 0) begin
      t = b; b = c; c = t;
    end
    set_triangle(a, b, c, 24'($urandom), 24'($urandom), 24'($urandom));
  endtask

  task automatic send_near_triangle();
    int lox, hix, loy, hiy;
    lox = int'(vert_a[31:16]); hix = lox;
    loy = int'(vert_a[15:0]);  hiy = loy;
    if (vert_b[31:16] < lox) lox = int'(vert_b[31:16]);
    if (vert_c[31:16] < lox) lox = int'(vert_c[31:16]);
    if (vert_b[31:16] > hix) hix = int'(vert_b[31:16]);
    if (vert_c[31:16] > hix) hix = int'(vert_c[31:16]);
    if (vert_b[15:0] < loy) loy = int'(vert_b[15:0]);
    if (vert_c[15:0] < loy) loy = int'(vert_c[15:0]);
    if (vert_b[15:0] > hiy) hiy = int'(vert_b[15:0]);
    if (vert_c[15:0] > hiy) hiy = int'(vert_c[15:0]);
    lox = lox >> FRAC; hix = hix >> FRAC; loy = loy >> FRAC; hiy = hiy >> FRAC;
    if (hix > 511) hix = 511;
    if (hiy > 511) hiy = 511;
    if (lox > hix) lox = hix;
    if (loy > hiy) loy = hiy;
    send_pixel(9'($urandom_range(lox, hix)), 9'($urandom_range(loy, hiy)));
  endtask

  task automatic test_random();
    for (int t = 0; t < 26; t++) begin
      random_triangle();
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 4) == 0) send_pixel(9'($urandom), 9'($urandom));
        else send_near_triangle();
      end
      drain();
    end
  endtask

  task automatic test_backpressure();
    set_triangle(fx(0, 0), fx(0, 40), fx(40, 0), 24'hFF00FF, 24'h00FFFF, 24'hFFFF00);
    hold_off <= 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_pixel(9'($urandom_range(0, 39)), 9'($urandom_range(0, 39)));
    end
    drain();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && !empty && pop) begin
      if (pending_pixels.size() == 0) begin
        $error("result with no pixel pending");
        n_errors++;
      end else begin
        pix_out_t e;
        e = pending_pixels.pop_front();
        if (out_data_o.covered !== e.covered) begin
          $error("covered: expected %0d, got %0d", e.covered, out_data_o.covered);
          n_errors++;
        end
        if (out_data_o.red_out !== e.red_out) begin
          $error("red_out: expected %0d, got %0d", e.red_out, out_data_o.red_out);
          n_errors++;
        end
        if (out_data_o.green_out !== e.green_out) begin
          $error("green_out: expected %0d, got %0d", e.green_out, out_data_o.green_out);
          n_errors++;
        end
        if (out_data_o.blue_out !== e.blue_out) begin
          $error("blue_out: expected %0d, got %0d", e.blue_out, out_data_o.blue_out);
          n_errors++;
        end
        if (out_data_o.pixel_index !== e.pixel_index) begin
          $error("pixel_index: expected %0d, got %0d", e.pixel_index,
                 out_data_o.pixel_index);
          n_errors++;
        end
        n_shaded++;
        if (e.covered) n_covered++;
      end
    end
  end

  // receiver stalls; a long hold-off is taken once when requested
  initial begin
    int g;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        pop <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      if ($urandom_range(0, 2) == 0) begin
        g = gap_len();
        if (g != 0) begin
          pop <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
      end
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    vert_a = '0; vert_b = '0; vert_c = '0;
    col_a = '0; col_b = '0; col_c = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_pixel(3, 3);
    drain();
    test_directed();
    test_backpressure();
    test_random();
    $display("shaded %0d of %0d pixels, %0d covered, across %0d triangle setups",
             n_shaded, n_pixels, n_covered, n_setups);
    if (n_errors == 0 && pending_pixels.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
